>>> rtl/aes256_block_encrypt_defines.svh
// Assertion macros for the AES-256 encrypt block
`ifndef AES256_BLOCK_ENCRYPT_DEFINES_SVH
`define AES256_BLOCK_ENCRYPT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AES_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("aes: forbidden condition");
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aes: implication failed");
`else
`define AES_ASSERT_NEVER(label, clk, rst_n, cond)
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/aes256_pkg.sv
// Types, constants and round functions shared by the AES-256 encrypt block
package aes256_pkg;

  localparam int unsigned KeyRegs   = 4;
  localparam int unsigned CfgIdxW   = 3;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } plain_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  typedef struct packed {
    logic         we;
    logic [3:0]   addr;
    logic [127:0] data;
  } rk_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte k of the state sits at bits [127-8k -: 8]; byte 4c+r is column c, row r
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32 * c -: 8];
      a1  = s[119 - 32 * c -: 8];
      a2  = s[111 - 32 * c -: 8];
      a3  = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

endpackage

>>> rtl/aes256_keyexp.sv
// Key registers and key expansion sequencer, one round-key row per cycle
module aes256_keyexp #(
  parameter int unsigned NumRows = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aes256_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i,
  output aes256_pkg::rk_wr_t            rk_wr_o,
  output logic                          busy_o,
  output logic                          keys_ready_o
);
  import aes256_pkg::*;

  logic [63:0]  key_q [KeyRegs];
  logic [255:0] win_q, win_d;
  logic [3:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, ready_q, ready_d;
  logic [7:0]   rc_q, rc_d;
  logic [127:0] row;
  logic [31:0]  t, w0, w1, w2, w3;
  logic         start;

  assign start = cfg_we_i && (cfg_idx_i < CfgIdxW'(KeyRegs));

  always_comb begin
    t = win_q[31:0];
    if (!cnt_q[0]) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'h0};
    end else begin
      t = sub_word(t);
    end
    w0 = win_q[255:224] ^ t;
    w1 = win_q[223:192] ^ w0;
    w2 = win_q[191:160] ^ w1;
    w3 = win_q[159:128] ^ w2;
    case (cnt_q)
      4'd0:    row = {key_q[0], key_q[1]};
      4'd1:    row = {key_q[2], key_q[3]};
      default: row = {w0, w1, w2, w3};
    endcase
  end

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rc_d    = rc_q;
    win_d   = win_q;
    ready_d = ready_q;
    if (start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rc_d   = 8'h01;
    end else if (busy_q) begin
      win_d = {win_q[127:0], row};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q >= 4'd2 && !cnt_q[0]) begin
        rc_d = xtime(rc_q);
      end
      if (cnt_q == 4'(NumRows - 1)) begin
        busy_d  = 1'b0;
        ready_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      ready_q <= 1'b0;
      cnt_q   <= '0;
      rc_q    <= 8'h01;
      for (int i = 0; i < KeyRegs; i++) key_q[i] <= '0;
    end else begin
      busy_q  <= busy_d;
      ready_q <= ready_d;
      cnt_q   <= cnt_d;
      rc_q    <= rc_d;
      if (start) begin
        key_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign rk_wr_o.we   = busy_q && !start;
  assign rk_wr_o.addr = cnt_q;
  assign rk_wr_o.data = row;
  assign busy_o       = busy_q;
  assign keys_ready_o = ready_q;
endmodule

>>> rtl/aes256_rkmem.sv
// Round-key memory: one 128-bit row per round, registered read
module aes256_rkmem #(
  parameter int unsigned NumRows = 15
) (
  input  logic               clk_i,
  input  aes256_pkg::rk_wr_t wr_i,
  input  logic [3:0]         rd_addr_i,
  output logic [127:0]       rd_data_o
);
  import aes256_pkg::*;

  logic [127:0] mem [NumRows];
  logic [127:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;
endmodule

>>> rtl/aes256_core.sv
// Round datapath: one round per cycle, last round held while a result is untaken; key read one round ahead
module aes256_core #(
  parameter int unsigned NumRounds = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                hold_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aes256_pkg::plain_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aes256_pkg::cipher_t out_data_o,
  output logic [3:0]          rd_addr_o,
  input  logic [127:0]        rk_i,
  output logic                busy_o
);
  import aes256_pkg::*;

  logic [127:0] st_q, st_d, res_q, res_d, ss;
  logic [3:0]   round_q, round_d;
  logic         busy_q, busy_d, ov_q, ov_d, acc, last;

  assign in_ready_o = !busy_q && !hold_i;
  assign acc        = in_valid_i && in_ready_o;
  assign last       = (round_q == 4'(NumRounds));
  assign ss         = sub_shift(st_q);

  always_comb begin
    st_d    = st_q;
    res_d   = res_q;
    round_d = round_q;
    busy_d  = busy_q;
    ov_d    = ov_q && !out_ready_i;
    if (acc) begin
      st_d    = {in_data_i.plain_high, in_data_i.plain_low};
      round_d = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (last) begin
        if (!ov_d) begin
          res_d  = ss ^ rk_i;
          ov_d   = 1'b1;
          busy_d = 1'b0;
        end
      end else begin
        st_d    = (round_q == '0) ? (st_q ^ rk_i) : (mix_columns(ss) ^ rk_i);
        round_d = round_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      ov_q    <= 1'b0;
      round_q <= '0;
    end else begin
      busy_q  <= busy_d;
      ov_q    <= ov_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    res_q <= res_d;
  end

  assign rd_addr_o   = round_d;
  assign out_valid_o = ov_q;
  assign out_data_o  = {res_q[127:64], res_q[63:0]};
  assign busy_o      = busy_q;
endmodule

>>> rtl/aes256_block_encrypt.sv
// AES-256 encrypt block, ECB, one 128-bit block per transfer
// One block at a time: a new block is accepted once the previous one has finished
//   its rounds, one round per cycle through the round-key memory read port, the
//   last round holding while a result waits; a waiting result does not block intake.
// Reset: clears control; key registers read zero. Each key register write
//   runs a key expansion of all round-key rows during which no input is taken.
module aes256_block_encrypt #(
  parameter int unsigned NUM_ROUNDS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aes256_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  aes256_pkg::plain_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output aes256_pkg::cipher_t           out_data_o
);
  import aes256_pkg::*;
`include "aes256_block_encrypt_defines.svh"

  localparam int unsigned NumRows = NUM_ROUNDS + 1;

  rk_wr_t       rk_wr;
  logic         kx_busy, keys_ready, core_busy;
  logic [3:0]   rd_addr;
  logic [127:0] rk;

  aes256_keyexp #(.NumRows(NumRows)) u_keyexp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .rk_wr_o(rk_wr), .busy_o(kx_busy), .keys_ready_o(keys_ready)
  );

  aes256_rkmem #(.NumRows(NumRows)) u_rkmem (
    .clk_i, .wr_i(rk_wr), .rd_addr_i(rd_addr), .rd_data_o(rk)
  );

  aes256_core #(.NumRounds(NUM_ROUNDS)) u_core (
    .clk_i, .rst_ni, .hold_i(kx_busy), .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .rd_addr_o(rd_addr), .rk_i(rk),
    .busy_o(core_busy)
  );

  `AES_ASSERT_NEVER(a_no_write_in_round, clk_i, rst_ni, rk_wr.we && core_busy)
  `AES_ASSERT_NEVER(a_no_take_in_expand, clk_i, rst_ni, in_ready_o && kx_busy)
  `AES_ASSERT_IMPL(a_ready_after_expand, clk_i, rst_ni, $fell(kx_busy), keys_ready)
endmodule
